// ----- rtl/mnpq_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package mnpq_pkg;

  localparam int unsigned MaxPoints = 1024;
  localparam int unsigned CoordBits = 20;
  localparam int unsigned DistBits  = CoordBits + 1;
  localparam int unsigned IdxBits   = (MaxPoints > 1) ? $clog2(MaxPoints) : 1;
  localparam int unsigned CntBits   = $clog2(MaxPoints + 1);

  typedef enum logic [0:0] {
    OP_INSERT = 1'b0,
    OP_QUERY  = 1'b1
  } op_e;

  // One item as it travels down the cell chain. For an insert, cnt is the
  // slot it will be written to; for a query, it is the number of points
  // stored when the query entered.
  typedef struct packed {
    logic                 valid;
    op_e                  op;
    logic [CoordBits-1:0] x;
    logic [CoordBits-1:0] y;
    logic [CntBits-1:0]   cnt;
    logic [DistBits-1:0]  best;
    logic                 empty;
    logic                 dropped;
  } item_t;

endpackage

`default_nettype wire

// ----- rtl/manhattan_nearest_point_query_top.sv -----
// Path: a query result passes through the register in each of the 1024 point
//   cells and then through the output register before it is shown.
// Throughput: one item per cycle; the whole cell chain advances together and
//   holds only while a finished result waits in the output register and the
//   next result has reached the end of the chain.
// Reset: rst_ni clears the point count, the dropped flag and all item valid
//   bits at once; stored points are undefined until written.
`timescale 1ns / 1ps
`default_nettype none

module manhattan_nearest_point_query_top (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 in_valid_i,
  output logic                                      in_ready_o,
  input  wire logic                                 opcode_i,
  input  wire logic [mnpq_pkg::CoordBits-1:0]       coord_x_i,
  input  wire logic [mnpq_pkg::CoordBits-1:0]       coord_y_i,
  output logic                                      out_valid_o,
  input  wire logic                                 out_ready_i,
  output logic [mnpq_pkg::DistBits-1:0]             distance_o,
  output logic                                      store_empty_o,
  output logic                                      inserts_dropped_o
);

  localparam logic [mnpq_pkg::CntBits-1:0] CntFull =
    mnpq_pkg::CntBits'(mnpq_pkg::MaxPoints);

  logic [mnpq_pkg::CntBits-1:0] count_q;
  logic [mnpq_pkg::CntBits-1:0] count_d;
  logic                         dropped_q;
  logic                         dropped_d;
  logic                         advance;
  logic                         accept;
  logic                         last_is_result;
  logic                         out_valid_q;
  logic [mnpq_pkg::DistBits-1:0] distance_q;
  logic                         empty_q;
  logic                         drop_out_q;

  mnpq_pkg::item_t chain [0:mnpq_pkg::MaxPoints];

  assign last_is_result = chain[mnpq_pkg::MaxPoints].valid &&
                          (chain[mnpq_pkg::MaxPoints].op == mnpq_pkg::OP_QUERY);
  assign advance        = !last_is_result || !out_valid_q || out_ready_i;
  assign in_ready_o     = advance;
  assign accept         = in_valid_i && advance;

  always_comb begin
    chain[0].valid   = accept;
    chain[0].op      = mnpq_pkg::op_e'(opcode_i);
    chain[0].x       = coord_x_i;
    chain[0].y       = coord_y_i;
    chain[0].cnt     = count_q;
    chain[0].best    = '1;
    chain[0].empty   = (count_q == '0);
    chain[0].dropped = dropped_q;
  end

  always_comb begin
    count_d   = count_q;
    dropped_d = dropped_q;
    if (accept && (mnpq_pkg::op_e'(opcode_i) == mnpq_pkg::OP_INSERT)) begin
      if (count_q == CntFull) begin
        dropped_d = 1'b1;
      end else begin
        count_d = count_q + mnpq_pkg::CntBits'(1);
      end
    end
  end

  for (genvar g = 0; g < mnpq_pkg::MaxPoints; g++) begin : g_cell
    mnpq_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (advance),
      .idx_i  (mnpq_pkg::IdxBits'(g)),
      .item_i (chain[g]),
      .item_o (chain[g+1])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      dropped_q   <= 1'b0;
      out_valid_q <= 1'b0;
      distance_q  <= '0;
      empty_q     <= 1'b0;
      drop_out_q  <= 1'b0;
    end else begin
      count_q   <= count_d;
      dropped_q <= dropped_d;
      // A waiting result stays until it is taken, even while bubbles move on.
      if (advance && last_is_result) begin
        out_valid_q <= 1'b1;
        distance_q  <= chain[mnpq_pkg::MaxPoints].best;
        empty_q     <= chain[mnpq_pkg::MaxPoints].empty;
        drop_out_q  <= chain[mnpq_pkg::MaxPoints].dropped;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o       = out_valid_q;
  assign distance_o        = distance_q;
  assign store_empty_o     = empty_q;
  assign inserts_dropped_o = drop_out_q;

endmodule

`default_nettype wire

// ----- rtl/mnpq_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none

module mnpq_cell (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              en_i,
  input  wire logic [mnpq_pkg::IdxBits-1:0]      idx_i,
  input  wire mnpq_pkg::item_t                   item_i,
  output mnpq_pkg::item_t                        item_o
);

  logic [mnpq_pkg::CoordBits-1:0] pt_x_q;
  logic [mnpq_pkg::CoordBits-1:0] pt_y_q;
  logic                           valid_q;
  mnpq_pkg::item_t                item_q;
  mnpq_pkg::item_t                item_d;
  logic [mnpq_pkg::CoordBits-1:0] dx;
  logic [mnpq_pkg::CoordBits-1:0] dy;
  logic [mnpq_pkg::DistBits-1:0]  pt_dist;
  logic [mnpq_pkg::CntBits-1:0]   idx_ext;
  logic                           write_en;
  logic                           use_pt;

  assign idx_ext = {{(mnpq_pkg::CntBits - mnpq_pkg::IdxBits){1'b0}}, idx_i};

  assign dx      = (item_i.x >= pt_x_q) ? (item_i.x - pt_x_q) : (pt_x_q - item_i.x);
  assign dy      = (item_i.y >= pt_y_q) ? (item_i.y - pt_y_q) : (pt_y_q - item_i.y);
  assign pt_dist = {1'b0, dx} + {1'b0, dy};

  // An insert owns exactly one cell; a full-store insert matches none.
  assign write_en = en_i && item_i.valid && (item_i.op == mnpq_pkg::OP_INSERT) &&
                    (item_i.cnt == idx_ext);
  // A query only looks at cells that were filled before it entered.
  assign use_pt   = (item_i.op == mnpq_pkg::OP_QUERY) && (idx_ext < item_i.cnt);

  always_comb begin
    item_d = item_i;
    if (use_pt && (pt_dist < item_i.best)) begin
      item_d.best = pt_dist;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= item_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      item_q <= item_d;
    end
    if (write_en) begin
      pt_x_q <= item_i.x;
      pt_y_q <= item_i.y;
    end
  end

  always_comb begin
    item_o       = item_q;
    item_o.valid = valid_q;
  end

endmodule

`default_nettype wire

// ----- rtl/mnpq_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module mnpq_checker (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  input  wire logic                           in_ready_o,
  input  wire logic                           out_valid_o,
  input  wire logic                           out_ready_i,
  input  wire logic [mnpq_pkg::DistBits-1:0]  distance_o,
  input  wire logic                           store_empty_o,
  input  wire logic                           inserts_dropped_o
);

  // A waiting result must not change before it is taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(distance_o) &&
    $stable(store_empty_o) && $stable(inserts_dropped_o))
    else $error("result changed while stalled");

  // An empty store always reports the all-ones distance.
  a_empty_dist: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && store_empty_o |-> (distance_o == '1))
    else $error("empty store with a real distance");

  // Once an insert has been lost, every later result reports it.
  a_drop_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    inserts_dropped_o |=> inserts_dropped_o)
    else $error("dropped flag cleared");

  // Input is only held off by a result that waits for the consumer.
  a_ready_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without a waiting result");

endmodule

bind manhattan_nearest_point_query_top mnpq_checker u_mnpq_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_valid_i),
  .in_ready_o        (in_ready_o),
  .out_valid_o       (out_valid_o),
  .out_ready_i       (out_ready_i),
  .distance_o        (distance_o),
  .store_empty_o     (store_empty_o),
  .inserts_dropped_o (inserts_dropped_o)
);

`default_nettype wire

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned RandomItems = 1880;
  localparam int unsigned HoldCycles  = 3000;
  localparam int unsigned DrainCycles = 1200;
  localparam int unsigned LimitCycles = 500000;
  localparam logic [mnpq_pkg::CoordBits-1:0] CoordMax = '1;

  typedef struct packed {
    logic [mnpq_pkg::DistBits-1:0] distance;
    logic                          empty;
    logic                          dropped;
  } nearest_result_t;

  // Tracks the stored points and works out the nearest distance for every query.
  class nearest_point_board;
    logic [mnpq_pkg::CoordBits-1:0] xs [mnpq_pkg::MaxPoints];
    logic [mnpq_pkg::CoordBits-1:0] ys [mnpq_pkg::MaxPoints];
    int unsigned                    stored;
    bit                             dropped;
    nearest_result_t                expected_q [$];
    int unsigned                    fails, checked, inserts, drops, queries, exact_hits;

    function void note_item(mnpq_pkg::op_e op, logic [mnpq_pkg::CoordBits-1:0] x,
                            logic [mnpq_pkg::CoordBits-1:0] y);
      nearest_result_t                res;
      logic [mnpq_pkg::DistBits-1:0]  d;
      logic [mnpq_pkg::CoordBits-1:0] dx, dy;
      if (op == mnpq_pkg::OP_INSERT) begin
        inserts++;
        if (stored < mnpq_pkg::MaxPoints) begin
          xs[stored] = x;
          ys[stored] = y;
          stored++;
        end else begin
          dropped = 1'b1;
          drops++;
        end
      end else begin
        queries++;
        res.distance = '1;
        res.empty    = (stored == 0);
        res.dropped  = dropped;
        for (int i = 0; i < stored; i++) begin
          dx = (x >= xs[i]) ? x - xs[i] : xs[i] - x;
          dy = (y >= ys[i]) ? y - ys[i] : ys[i] - y;
          d  = mnpq_pkg::DistBits'(dx) + mnpq_pkg::DistBits'(dy);
          if (d < res.distance) res.distance = d;
        end
        if (!res.empty && res.distance == '0) exact_hits++;
        expected_q.push_back(res);
      end
    endfunction

    function void check_result(logic [mnpq_pkg::DistBits-1:0] got_distance, logic empty,
                               logic got_dropped);
      nearest_result_t exp_res;
      if (expected_q.size() == 0) begin
        $error("result with no query outstanding: distance %0d", got_distance);
        fails++;
      end else begin
        exp_res = expected_q.pop_front();
        checked++;
        if (got_distance !== exp_res.distance) begin
          $error("distance: expected %0d, got %0d", exp_res.distance, got_distance);
          fails++;
        end
        if (empty !== exp_res.empty) begin
          $error("store_empty: expected %0d, got %0d", exp_res.empty, empty);
          fails++;
        end
        if (got_dropped !== exp_res.dropped) begin
          $error("inserts_dropped: expected %0d, got %0d", exp_res.dropped, got_dropped);
          fails++;
        end
      end
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           in_valid = 1'b0;
  mnpq_pkg::op_e                  opcode = mnpq_pkg::OP_INSERT;
  logic [mnpq_pkg::CoordBits-1:0] coord_x = '0;
  logic [mnpq_pkg::CoordBits-1:0] coord_y = '0;
  logic                           out_ready = 1'b0;
  logic                           hold_rx = 1'b0;
  logic                           in_ready_o, out_valid_o, store_empty_o, inserts_dropped_o;
  logic [mnpq_pkg::DistBits-1:0]  distance_o;

  nearest_point_board   sb = new();
  int unsigned          tx_calm = 0;
  int unsigned          rx_calm = 0;
  int unsigned          rx_stall = 0;
  int unsigned          in_stalls = 0;
  int unsigned          cycle_count = 0;

  manhattan_nearest_point_query_top dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready_o),
    .opcode_i         (opcode),
    .coord_x_i        (coord_x),
    .coord_y_i        (coord_y),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready),
    .distance_o       (distance_o),
    .store_empty_o    (store_empty_o),
    .inserts_dropped_o(inserts_dropped_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= LimitCycles) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Mostly short gaps, a few long ones, and now and then a calm stretch with none.
  function automatic int unsigned idle_gap(ref int unsigned calm);
    int unsigned r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 149) == 0) calm = $urandom_range(30, 150);
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_item(input mnpq_pkg::op_e op, input logic [mnpq_pkg::CoordBits-1:0] x,
                           input logic [mnpq_pkg::CoordBits-1:0] y);
    int unsigned gap;
    gap = idle_gap(tx_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    opcode   <= op;
    coord_x  <= x;
    coord_y  <= y;
    do begin
      @(posedge clk_i);
      if (!in_ready_o) in_stalls++;
    end while (!in_ready_o);
    sb.note_item(op, x, y);
  endtask

  // Points are spread over the whole range, packed near the all-zero and all-ones
  // corners, or placed close to a point already stored so that small distances show up often.
  task automatic pick_point(output logic [mnpq_pkg::CoordBits-1:0] x,
                            output logic [mnpq_pkg::CoordBits-1:0] y);
    int unsigned idx;
    case ($urandom_range(0, 3))
      0: begin
        x = mnpq_pkg::CoordBits'($urandom());
        y = mnpq_pkg::CoordBits'($urandom());
      end
      1: begin
        x = mnpq_pkg::CoordBits'($urandom_range(0, 15));
        y = mnpq_pkg::CoordBits'($urandom_range(0, 15));
      end
      2: begin
        x = CoordMax - mnpq_pkg::CoordBits'($urandom_range(0, 15));
        y = CoordMax - mnpq_pkg::CoordBits'($urandom_range(0, 15));
      end
      default: begin
        if (sb.stored == 0) begin
          x = mnpq_pkg::CoordBits'($urandom());
          y = mnpq_pkg::CoordBits'($urandom());
        end else begin
          idx = $urandom_range(0, sb.stored - 1);
          x = sb.xs[idx] + mnpq_pkg::CoordBits'($urandom_range(0, 8)) -
              mnpq_pkg::CoordBits'(4);
          y = sb.ys[idx] + mnpq_pkg::CoordBits'($urandom_range(0, 8)) -
              mnpq_pkg::CoordBits'(4);
        end
      end
    endcase
  endtask

  initial begin
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready) begin
        sb.check_result(distance_o, store_empty_o, inserts_dropped_o);
      end
      if (hold_rx) begin
        out_ready <= 1'b0;
      end else if (rx_stall > 0) begin
        rx_stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        rx_stall = idle_gap(rx_calm);
      end
    end
  end

  // Once results flow, hold the output off long enough to back the whole chain up.
  initial begin
    do @(posedge clk_i); while (sb.checked < 24);
    hold_rx <= 1'b1;
    repeat (HoldCycles) @(posedge clk_i);
    hold_rx <= 1'b0;
  end

  initial begin
    mnpq_pkg::op_e                  op;
    logic [mnpq_pkg::CoordBits-1:0] x, y;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_item(mnpq_pkg::OP_QUERY, '0, '0);
    send_item(mnpq_pkg::OP_QUERY, CoordMax, CoordMax);
    send_item(mnpq_pkg::OP_INSERT, '0, '0);
    send_item(mnpq_pkg::OP_QUERY, CoordMax, CoordMax);
    send_item(mnpq_pkg::OP_QUERY, '0, '0);
    send_item(mnpq_pkg::OP_QUERY, CoordMax, '0);
    send_item(mnpq_pkg::OP_INSERT, CoordMax, CoordMax);
    send_item(mnpq_pkg::OP_QUERY, CoordMax, CoordMax);
    send_item(mnpq_pkg::OP_QUERY, 20'h80000, 20'h7FFFF);
    send_item(mnpq_pkg::OP_INSERT, '0, '0);
    send_item(mnpq_pkg::OP_INSERT, 20'h55555, 20'hAAAAA);
    send_item(mnpq_pkg::OP_QUERY, 20'hAAAAA, 20'h55555);
    send_item(mnpq_pkg::OP_INSERT, 20'hAAAAA, 20'h55555);
    send_item(mnpq_pkg::OP_QUERY, 20'h55555, 20'hAAAAA);
    send_item(mnpq_pkg::OP_QUERY, 20'h00001, '0);
    send_item(mnpq_pkg::OP_QUERY, CoordMax - 20'd1, CoordMax);

    for (int i = 0; i < RandomItems; i++) begin
      op = ($urandom_range(0, 9) < 6) ? mnpq_pkg::OP_INSERT : mnpq_pkg::OP_QUERY;
      pick_point(x, y);
      send_item(op, x, y);
    end

    // Make sure the store fills, then push a few inserts past the end.
    while (sb.stored < mnpq_pkg::MaxPoints) begin
      pick_point(x, y);
      send_item(mnpq_pkg::OP_INSERT, x, y);
    end
    for (int i = 0; i < 3; i++) begin
      pick_point(x, y);
      send_item(mnpq_pkg::OP_INSERT, x, y);
    end
    for (int i = 0; i < 4; i++) begin
      pick_point(x, y);
      send_item(mnpq_pkg::OP_QUERY, x, y);
    end
    in_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Sent %0d inserts (%0d lost to a full store) and %0d queries, %0d exact hits.",
             sb.inserts, sb.drops, sb.queries, sb.exact_hits);
    $display("Checked %0d results; input stalled %0d cycles around a %0d-cycle output hold.",
             sb.checked, in_stalls, HoldCycles);
    if (sb.fails == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
